// File: hdl/rnc_pkg.sv
// Package with shared constants, codes and helper functions of the radix number converter.
`default_nettype none
package rnc_pkg;
  localparam int WholeBitsDefault     = 32;
  localparam int FracInDigitsDefault  = 8;
  localparam int FracOutDigitsDefault = 8;

  localparam logic [4:0] SourceRadixReset = 5'd10;
  localparam logic [4:0] TargetRadixReset = 5'd2;

  localparam logic [0:0] RegSourceRadix = 1'b0;
  localparam logic [0:0] RegTargetRadix = 1'b1;

  localparam logic [2:0] StOk    = 3'd0;
  localparam logic [2:0] StRadix = 3'd1;
  localparam logic [2:0] StChar  = 3'd2;
  localparam logic [2:0] StDigit = 3'd3;
  localparam logic [2:0] StOvf   = 3'd4;

  localparam logic [7:0] CharPoint = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [4:0] NotDigit  = 5'd16;

  function automatic logic radix_ok(input logic [4:0] r);
    radix_ok = (r == 5'd2) || (r == 5'd3) || (r == 5'd4) || (r == 5'd5) ||
               (r == 5'd6) || (r == 5'd8) || (r == 5'd10) || (r == 5'd12) ||
               (r == 5'd16);
  endfunction

  function automatic logic [4:0] char_value(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (c >= CharZero && c <= 8'h39) begin
        d = c - CharZero;
      end else if (c >= CharLowA && c <= 8'h66) begin
        d = c - CharLowA + 8'd10;
      end else if (c >= CharUpA && c <= 8'h46) begin
        d = c - CharUpA + 8'd10;
      end else begin
        d = {3'd0, NotDigit};
      end
      char_value = d[4:0];
    end
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    if (d < 4'd10) begin
      digit_char = CharZero + {4'd0, d};
    end else begin
      digit_char = CharUpA + {4'd0, d} - 8'd10;
    end
  endfunction
endpackage
`default_nettype wire

// File: hdl/radix_number_converter.sv
// Top level of the radix number converter: digit accumulation and sequenced conversion.
//
//   channel  direction  signals
//   config   in         cfg_we, cfg_index, cfg_data
//   input    in         in_valid, in_stall, in_char, in_last
//   output   out        out_valid, out_stall, out_char, out_last, status
//
// A character without the last mark is absorbed directly while the converter is idle.
// On the last character one shared shift-subtract divider makes one quotient bit per cycle,
// in S_WDIV for each whole digit and in S_FDIV for each fraction digit, whose denominator is DW
// bits wide; S_WHOLE places the zero and the point, and S_LOAD places the first word.
// Results wait in a character buffer, then leave one word per accepted cycle.
// Reset is synchronous; input stall stays high from the last character until the last word
// leaves, and output stall only holds the current word.
`default_nettype none
module radix_number_converter
  import rnc_pkg::*;
#(
  parameter int WHOLE_BITS      = WholeBitsDefault,
  parameter int FRAC_IN_DIGITS  = FracInDigitsDefault,
  parameter int FRAC_OUT_DIGITS = FracOutDigitsDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [4:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_char,
  output logic            out_last,
  output logic [2:0]      status
);
  localparam int DW   = 4 * FRAC_IN_DIGITS + 1;
  localparam int WW   = (WHOLE_BITS > DW) ? WHOLE_BITS : DW;
  localparam int NW   = WW + 5;
  localparam int BUF  = WHOLE_BITS + 1 + FRAC_OUT_DIGITS;
  localparam int BW   = $clog2(BUF + 1);
  localparam int AW   = $clog2(BUF);
  localparam int CW   = $clog2(NW + 1);
  localparam int FCW  = $clog2(FRAC_IN_DIGITS + 1);
  localparam int KW   = $clog2(FRAC_OUT_DIGITS + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_WHOLE = 7'b0000010,
    S_WDIV  = 7'b0000100,
    S_FRAC  = 7'b0001000,
    S_FDIV  = 7'b0010000,
    S_LOAD  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state;
  logic [4:0] source_radix, target_radix;
  logic [WHOLE_BITS-1:0] whole_value;
  logic [DW-1:0] frac_numerator, frac_denominator;
  logic [FCW-1:0] frac_digit_count;
  logic seen_point;
  logic [2:0] error_code;

  logic [NW-1:0] dividend, divisor_reg, rem_reg;
  logic [CW-1:0] bit_cnt;
  logic [CW-1:0] bit_total;
  logic [BW-1:0] wcount;
  logic [KW-1:0] fcount;
  logic [7:0] obuf [BUF];
  logic [BW-1:0] olen, optr;
  logic [2:0] ostatus;

  logic accept;
  logic [4:0] dval;
  logic [WHOLE_BITS+4:0] wprod;
  logic [NW:0] trial;
  logic [NW-1:0] rem_shift;
  logic [BW-1:0] rd_idx;
  logic [AW-1:0] raddr;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign dval      = char_value(in_char);
  assign wprod     = whole_value * source_radix + {{WHOLE_BITS{1'b0}}, dval};
  assign rem_shift = {rem_reg[NW-2:0], dividend[NW-1]};
  assign trial     = {1'b0, rem_shift} - {1'b0, divisor_reg};
  assign out_valid = (state == S_EMIT);
  assign out_last  = (optr == olen - BW'(1));
  assign status    = ostatus;

  // Whole digits sit in the buffer least significant first, so they are read backward.
  assign rd_idx = (state == S_LOAD) ? '0 : optr + BW'(1);
  assign raddr  = (rd_idx < wcount) ? AW'(wcount - rd_idx - BW'(1)) : AW'(rd_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      source_radix <= SourceRadixReset;
      target_radix <= TargetRadixReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegSourceRadix: source_radix <= cfg_data;
        RegTargetRadix: target_radix <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      whole_value <= '0;
      frac_numerator <= '0;
      frac_denominator <= DW'(1);
      frac_digit_count <= '0;
      seen_point <= 1'b0;
      error_code <= StOk;
      optr <= '0;
      olen <= '0;
      wcount <= '0;
      fcount <= '0;
      bit_cnt <= '0;
      ostatus <= StOk;
      out_char <= 8'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            logic [2:0] e;
            e = error_code;
            if (e == StOk) begin
              if (in_char == CharPoint) begin
                if (seen_point) e = StChar;
                else seen_point <= 1'b1;
              end else if (dval == NotDigit) begin
                e = StChar;
              end else if (dval >= source_radix) begin
                e = StDigit;
              end else if (!seen_point) begin
                if (wprod[WHOLE_BITS+4:WHOLE_BITS] != '0) e = StOvf;
                else whole_value <= wprod[WHOLE_BITS-1:0];
              end else if (frac_digit_count < FCW'(FRAC_IN_DIGITS)) begin
                frac_numerator <= DW'(frac_numerator * source_radix + DW'(dval));
                frac_denominator <= DW'(frac_denominator * source_radix);
                frac_digit_count <= frac_digit_count + FCW'(1);
              end
            end
            error_code <= e;
            if (in_last) begin
              optr <= '0;
              if (!radix_ok(source_radix) || !radix_ok(target_radix) ||
                  source_radix == target_radix) e = StRadix;
              if (e != StOk) begin
                ostatus <= e;
                out_char <= 8'd0;
                olen <= BW'(1);
                state <= S_EMIT;
              end else begin
                ostatus <= StOk;
                wcount <= '0;
                state <= S_WHOLE;
              end
            end
          end
        end
        S_WHOLE: begin
          if (whole_value != '0) begin
            dividend <= NW'(whole_value) << (NW - WHOLE_BITS);
            divisor_reg <= NW'(target_radix);
            rem_reg <= '0;
            bit_cnt <= '0;
            bit_total <= CW'(WHOLE_BITS);
            state <= S_WDIV;
          end else if (wcount == '0) begin
            obuf[AW'(0)] <= CharZero;
            wcount <= BW'(1);
          end else begin
            fcount <= '0;
            if (frac_numerator != '0) begin
              obuf[AW'(wcount)] <= CharPoint;
              olen <= wcount + BW'(1);
              state <= S_FRAC;
            end else begin
              olen <= wcount;
              state <= S_LOAD;
            end
          end
        end
        S_WDIV: begin
          if (!trial[NW]) rem_reg <= trial[NW-1:0];
          else rem_reg <= rem_shift;
          dividend <= {dividend[NW-2:0], !trial[NW]};
          bit_cnt <= bit_cnt + CW'(1);
          if (bit_cnt == bit_total - CW'(1)) begin
            whole_value <= WHOLE_BITS'({dividend[NW-2:0], !trial[NW]});
            obuf[AW'(wcount)] <= digit_char((!trial[NW]) ? trial[3:0] : rem_shift[3:0]);
            wcount <= wcount + BW'(1);
            state <= S_WHOLE;
          end
        end
        S_FRAC: begin
          if (frac_numerator == '0 || fcount == KW'(FRAC_OUT_DIGITS)) begin
            state <= S_LOAD;
          end else begin
            dividend <= (NW'(frac_numerator) * NW'(target_radix)) << (NW - DW - 5);
            divisor_reg <= NW'(frac_denominator);
            rem_reg <= '0;
            bit_cnt <= '0;
            bit_total <= CW'(DW + 5);
            state <= S_FDIV;
          end
        end
        S_FDIV: begin
          if (!trial[NW]) rem_reg <= trial[NW-1:0];
          else rem_reg <= rem_shift;
          dividend <= {dividend[NW-2:0], !trial[NW]};
          bit_cnt <= bit_cnt + CW'(1);
          if (bit_cnt == bit_total - CW'(1)) begin
            frac_numerator <= DW'((!trial[NW]) ? trial[NW-1:0] : rem_shift);
            obuf[AW'(olen)] <= digit_char({dividend[2:0], !trial[NW]});
            olen <= olen + BW'(1);
            fcount <= fcount + KW'(1);
            state <= S_FRAC;
          end
        end
        S_LOAD: begin
          out_char <= obuf[raddr];
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_stall) begin
            if (out_last) begin
              whole_value <= '0;
              frac_numerator <= '0;
              frac_denominator <= DW'(1);
              frac_digit_count <= '0;
              seen_point <= 1'b0;
              error_code <= StOk;
              optr <= '0;
              state <= S_IDLE;
            end else begin
              optr <= optr + BW'(1);
              out_char <= obuf[raddr];
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
